// ===== rtl/assert_macros.svh =====
// assertion macros shared by the allocator rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define AST_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen outside reset
`define AST_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define AST_HOLDS(lbl, clk, rst_n, prop, msg)
`define AST_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

// ===== rtl/cba_pkg.sv =====
// types, result codes and helpers for the contiguous block allocator
// no dependencies
package cba_pkg;

	localparam int ROW_BITS = 8;   // blocks per bitmap memory word
	localparam int FILE_W   = 16;
	localparam int LEN_W    = 9;
	localparam int BLK_W    = 10;  // wide enough for start + count
	localparam int REC_W    = FILE_W + LEN_W;

	typedef enum logic [2:0] {
		ST_GRANTED   = 3'd0,
		ST_BUSY      = 3'd1,
		ST_PAST_END  = 3'd2,
		ST_FULL      = 3'd3,
		ST_FOUND     = 3'd4,
		ST_NOT_FOUND = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_MARK_RD,
		S_MARK_WR,
		S_GRANT,
		S_LOOK,
		S_EMIT
	} state_t;

	// bits of one bitmap word that fall inside [first, last_ex)
	function automatic logic [ROW_BITS-1:0] range_mask(
		input logic [BLK_W-1:0] row_base,
		input logic [BLK_W-1:0] first,
		input logic [BLK_W-1:0] last_ex
	);
		logic [ROW_BITS-1:0] m;
		logic [BLK_W-1:0]    blk;
		for (int b = 0; b < ROW_BITS; b++) begin
			blk  = row_base + BLK_W'(b);
			m[b] = (blk >= first) && (blk < last_ex);
		end
		return m;
	endfunction

endpackage

// ===== rtl/cba_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module cba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [$clog2((DEPTH > 1) ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/contiguous_block_allocator.sv =====
// contiguous block allocator: block bitmap in memory, 8 blocks a word, and a file record memory
// operation: allocate runs a check pass over its bitmap words, then a mark pass; lookup scans the records,
// rejects found at accept go straight to the output; one item is in work at a time, set by the single
// read port of each memory (check pass, read-modify-write mark pass, record scan)
// reset: counters zero and the per-word valid bits of the bitmap cleared, so every block
// reads free at once with no clearing pass; record memory is left unwritten
// uses cba_pkg, cba_ram and assert_macros.svh
`include "assert_macros.svh"

module contiguous_block_allocator #(
	parameter int DISK_BLOCKS   = 256,
	parameter int TABLE_ENTRIES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  start_block,
	input  logic [8:0]  block_count,
	input  logic [15:0] query_file,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] file_id,
	output logic [8:0]  occupied
);
	// the bitmap holds at most 512 blocks, though a range can reach past start 255 + count 511
	localparam int MAP_BLOCKS = (DISK_BLOCKS < 512) ? DISK_BLOCKS : 512;
	localparam int ROWS       = (MAP_BLOCKS + cba_pkg::ROW_BITS - 1) / cba_pkg::ROW_BITS;
	localparam int RA_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int TI_W       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W      = $clog2(TABLE_ENTRIES + 1);
	localparam logic [16:0]      DISK_LIM = 17'(DISK_BLOCKS);
	localparam logic [CNT_W-1:0] TBL_FULL = CNT_W'(TABLE_ENTRIES);

	localparam int BW = cba_pkg::BLK_W;
	localparam int RB = cba_pkg::ROW_BITS;
	localparam int LW = cba_pkg::LEN_W;

	cba_pkg::state_t state_q, state_d;

	// persistent counters
	logic [15:0]      req_num_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROWS-1:0]  vld_q;       // bitmap word has been written since reset

	// current item
	logic [BW-1:0]    start_q, end_q;
	logic [LW-1:0]    count_q;
	logic [15:0]      id_q;        // number handed out, or the queried file
	logic [RA_W-1:0]  row_q, first_row_q, last_row_q;
	logic [TI_W-1:0]  idx_q, last_idx_q;
	logic             iss_done_q;  // every read of the scan is issued

	// read in flight, registered in the cycle after the issue
	logic             chk_s1;
	logic [RA_W-1:0]  chk_row_s1;
	logic [TI_W-1:0]  idx_s1;
	logic             vld_s1;

	// pending result
	cba_pkg::status_t res_status_q;
	logic [LW-1:0]    res_occ_q;

	// output register
	logic             out_valid_q;
	cba_pkg::status_t out_status_q;
	logic [15:0]      out_id_q;
	logic [LW-1:0]    out_occ_q;

	// memory ports
	logic                      bm_we, bm_re;
	logic [RB-1:0]             bm_wdata, bm_rdata;
	logic                      rec_we, rec_re;
	logic [cba_pkg::REC_W-1:0] rec_wdata, rec_rdata;

	// combinational helpers
	logic             in_fire, out_free;
	logic [BW-1:0]    req_start, req_end, req_end_m1;
	logic             past_end, tbl_full;
	logic [15:0]      req_num_nx;
	logic [RA_W-1:0]  mask_row;
	logic [RB-1:0]    row_mask, bm_word;
	logic             busy_hit, chk_last, look_hit, look_last;
	logic [15:0]      rec_file;
	logic [LW-1:0]    rec_len;

	assign in_ready = (state_q == cba_pkg::S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	assign req_start  = BW'(start_block);
	assign req_end    = BW'(start_block) + BW'(block_count);
	assign req_end_m1 = req_end - BW'(1);
	assign past_end   = 17'(req_end) > DISK_LIM;
	assign tbl_full   = (cnt_q == TBL_FULL);
	// file numbers saturate at the top of the 16-bit range
	assign req_num_nx = (req_num_q == 16'hFFFF) ? req_num_q : req_num_q + 16'd1;

	// the check pass masks the word just read, the mark pass the word being rewritten
	assign mask_row = (state_q == cba_pkg::S_CHECK) ? chk_row_s1 : row_q;
	assign row_mask = cba_pkg::range_mask(BW'({mask_row, 3'b000}), start_q, end_q);
	assign bm_word  = vld_s1 ? bm_rdata : '0;   // an unwritten word reads as all free

	assign busy_hit  = chk_s1 && (|(bm_word & row_mask));
	assign chk_last  = chk_s1 && (chk_row_s1 == last_row_q);

	assign rec_file  = rec_rdata[cba_pkg::REC_W-1:LW];
	assign rec_len   = rec_rdata[LW-1:0];
	assign look_hit  = chk_s1 && (rec_file == id_q);
	assign look_last = chk_s1 && (idx_s1 == last_idx_q);

	// memory controls
	assign bm_re     = ((state_q == cba_pkg::S_CHECK) && !iss_done_q)
	                   || (state_q == cba_pkg::S_MARK_RD);
	assign bm_we     = (state_q == cba_pkg::S_MARK_WR);
	assign bm_wdata  = bm_word | row_mask;
	assign rec_re    = (state_q == cba_pkg::S_LOOK) && !iss_done_q;
	assign rec_we    = (state_q == cba_pkg::S_GRANT);
	assign rec_wdata = {id_q, count_q};

	cba_ram #(
		.WIDTH (RB),
		.DEPTH (ROWS)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we),
		.waddr (row_q),
		.wdata (bm_wdata),
		.re    (bm_re),
		.raddr (row_q),
		.rdata (bm_rdata)
	);

	cba_ram #(
		.WIDTH (cba_pkg::REC_W),
		.DEPTH (TABLE_ENTRIES)
	) u_records (
		.clk   (clk),
		.we    (rec_we),
		.waddr (cnt_q[TI_W-1:0]),
		.wdata (rec_wdata),
		.re    (rec_re),
		.raddr (idx_q),
		.rdata (rec_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			cba_pkg::S_IDLE: begin
				if (in_fire) begin
					if (action) begin
						state_d = (cnt_q == '0) ? cba_pkg::S_EMIT : cba_pkg::S_LOOK;
					end else if (past_end || tbl_full) begin
						state_d = cba_pkg::S_EMIT;
					end else if (block_count == '0) begin
						state_d = cba_pkg::S_GRANT;   // empty range: record only
					end else begin
						state_d = cba_pkg::S_CHECK;
					end
				end
			end
			cba_pkg::S_CHECK: begin
				if (busy_hit) begin
					state_d = cba_pkg::S_EMIT;
				end else if (chk_last) begin
					state_d = cba_pkg::S_MARK_RD;
				end
			end
			cba_pkg::S_MARK_RD: state_d = cba_pkg::S_MARK_WR;
			cba_pkg::S_MARK_WR: begin
				state_d = (row_q == last_row_q) ? cba_pkg::S_GRANT : cba_pkg::S_MARK_RD;
			end
			cba_pkg::S_GRANT:   state_d = cba_pkg::S_EMIT;
			cba_pkg::S_LOOK: begin
				if (look_hit || look_last) begin
					state_d = cba_pkg::S_EMIT;
				end
			end
			cba_pkg::S_EMIT: begin
				if (out_free) begin
					state_d = cba_pkg::S_IDLE;
				end
			end
			default: state_d = cba_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_num_q   <= '0;
			cnt_q       <= '0;
			vld_q       <= '0;
			iss_done_q  <= 1'b0;
			chk_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			chk_s1 <= ((state_q == cba_pkg::S_CHECK) && !iss_done_q) || rec_re;

			if (in_fire) begin
				iss_done_q <= 1'b0;
				if (!action) begin
					req_num_q <= req_num_nx;
				end
			end else if ((state_q == cba_pkg::S_CHECK) && !iss_done_q
			             && (row_q == last_row_q)) begin
				iss_done_q <= 1'b1;
			end else if (rec_re && (idx_q == last_idx_q)) begin
				iss_done_q <= 1'b1;
			end

			if (bm_we) begin
				vld_q[row_q] <= 1'b1;
			end
			if (rec_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end

			if ((state_q == cba_pkg::S_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (bm_re) begin
			chk_row_s1 <= row_q;
			vld_s1     <= vld_q[row_q];
		end
		idx_s1 <= idx_q;

		case (state_q)
			cba_pkg::S_IDLE: begin
				if (in_fire) begin
					start_q     <= req_start;
					end_q       <= req_end;
					count_q     <= block_count;
					id_q        <= action ? query_file : req_num_nx;
					row_q       <= req_start[RA_W+2:3];
					first_row_q <= req_start[RA_W+2:3];
					last_row_q  <= req_end_m1[RA_W+2:3];
					idx_q       <= '0;
					last_idx_q  <= TI_W'(cnt_q - CNT_W'(1));
					res_occ_q   <= '0;
					if (action) begin
						res_status_q <= cba_pkg::ST_NOT_FOUND;
					end else if (past_end) begin
						res_status_q <= cba_pkg::ST_PAST_END;
					end else begin
						res_status_q <= cba_pkg::ST_FULL;
					end
				end
			end
			cba_pkg::S_CHECK: begin
				if (!iss_done_q && (row_q != last_row_q)) begin
					row_q <= row_q + RA_W'(1);
				end
				if (busy_hit) begin
					res_status_q <= cba_pkg::ST_BUSY;
				end else if (chk_last) begin
					row_q <= first_row_q;   // rewind for the mark pass
				end
			end
			cba_pkg::S_MARK_WR: begin
				if (row_q != last_row_q) begin
					row_q <= row_q + RA_W'(1);
				end
			end
			cba_pkg::S_GRANT: begin
				res_status_q <= cba_pkg::ST_GRANTED;
				res_occ_q    <= count_q;
			end
			cba_pkg::S_LOOK: begin
				if (rec_re && (idx_q != last_idx_q)) begin
					idx_q <= idx_q + TI_W'(1);
				end
				// earliest stored match wins
				if (look_hit) begin
					res_status_q <= cba_pkg::ST_FOUND;
					res_occ_q    <= rec_len;
				end
			end
			cba_pkg::S_EMIT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_id_q     <= id_q;
					out_occ_q    <= res_occ_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status    = out_status_q;
	assign file_id   = out_id_q;
	assign occupied  = out_occ_q;

	// checks
	`AST_NEVER(a_cnt_range, clk, arst_n, cnt_q > TBL_FULL, "record count beyond table size")
	`AST_HOLDS(a_cnt_step, clk, arst_n, rec_we |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "record count did not advance on store")
	`AST_HOLDS(a_req_mono, clk, arst_n, ##1 (req_num_q >= $past(req_num_q)), "file number went backwards")
	`AST_NEVER(a_chk_row, clk, arst_n, (state_q == cba_pkg::S_CHECK) && chk_s1 && (chk_row_s1 > last_row_q), "bitmap check read past the last word")
	`AST_NEVER(a_rec_rw, clk, arst_n, rec_we && rec_re, "record memory written during a scan")

endmodule
